// ===== src/lvp_pkg.sv =====
// Shared types and constants of the load value predictor.
// Depends on nothing; every other file of the block imports it.
package lvp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned BiasW    = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIT_THRESHOLD   = 3'd0,
    CFG_MISS_THRESHOLD  = 3'd1,
    CFG_RESET_TO        = 3'd2,
    CFG_DECREMENT_BY    = 3'd3,
    CFG_INITIAL_QUALITY = 3'd4,
    CFG_BIAS_START      = 3'd5
  } lvp_cfg_e;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  localparam logic signed [BiasW-1:0] BIAS_MAX = 7'sd63;
  localparam logic signed [BiasW-1:0] BIAS_MIN = -7'sd64;

  typedef struct packed {
    logic               command;
    logic               thread;
    logic [63:0]        load_pc;
    logic [63:0]        loaded_value;
    logic [63:0]        predicted_value;
    logic signed [7:0]  predicted_confidence;
  } lvp_in_t;

  typedef struct packed {
    logic [63:0]        value_guess;
    logic signed [7:0]  confidence_out;
    logic               not_mispredicted;
  } lvp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat
    logic rd_en;   // read the table entry
    logic ex_en;   // evaluate, write back an update and present the result
    logic clr_en;  // write one entry of the clearing sweep
  } lvp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_done;   // table index is ready
    logic clr_last;   // clearing sweep is at its last entry
    logic reclear;    // initial quality is being written
    logic out_stall;  // output register is full and not being taken
  } lvp_status_t;

endpackage

// ===== src/lvp_ctrl.sv =====
// Controller of the load value predictor: sequences clearing, indexing,
// table read and evaluation of one beat at a time.
// Depends on lvp_pkg.
module lvp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lvp_pkg::lvp_status_t status_i,
  output lvp_pkg::lvp_cmd_t   cmd_o
);
  import lvp_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_EXEC
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE) && !status_i.reclear;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.rd_en  = (state_q == S_INDEX) && status_i.idx_done;
    cmd_o.ex_en  = (state_q == S_EXEC) && !status_i.out_stall;
    cmd_o.clr_en = (state_q == S_CLEAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else if (status_i.reclear) begin
      state_q <= S_CLEAR;
    end else begin
      unique case (state_q)
        S_CLEAR: if (status_i.clr_last) state_q <= S_IDLE;
        S_IDLE:  if (cmd_o.load) state_q <= S_INDEX;
        S_INDEX: if (status_i.idx_done) state_q <= S_EXEC;
        S_EXEC:  if (cmd_o.ex_en) state_q <= S_IDLE;
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  a_exec_after_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $past(state_q == S_INDEX || state_q == S_EXEC))
    else $error("evaluation entered without a table read");

  a_load_to_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_INDEX))
    else $error("accepted beat did not start indexing");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && status_i.clr_last && !status_i.reclear) |=> (state_q == S_IDLE))
    else $error("clearing sweep did not finish");

endmodule

// ===== src/lvp_datapath.sv =====
// Datapath of the load value predictor: configuration registers, index
// reduction, the value/counter table, bias and hit/miss counts, output register.
// Depends on lvp_pkg.
module lvp_datapath #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned THREADS       = 2,
  parameter int unsigned COUNTER_BITS  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lvp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lvp_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  lvp_pkg::lvp_in_t                  in_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output lvp_pkg::lvp_out_t                 out_data_o,
  input  lvp_pkg::lvp_cmd_t                 cmd_i,
  output lvp_pkg::lvp_status_t              status_o
);
  import lvp_pkg::*;

  localparam int unsigned IW      = $clog2(TABLE_ENTRIES);
  localparam int unsigned EntUsed = ((THREADS > 1) ? 2 : 1) * TABLE_ENTRIES;
  localparam int unsigned MAW     = $clog2(EntUsed);
  localparam int unsigned MW      = 64 + COUNTER_BITS;
  localparam logic [7:0]  CMAX8   = 8'((1 << COUNTER_BITS) - 1);
  localparam bit          Pow2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  // Configuration registers.
  logic [7:0]              hit_th_q, miss_th_q;
  logic [3:0]              reset_to_q, dec_q, iq_q;

  // Running state.
  logic [7:0]              hit_q, miss_q;
  logic signed [BiasW-1:0] bias_q;
  logic [MAW-1:0]          clr_addr_q;

  lvp_in_t                 in_q;
  logic [IW-1:0]           idx;
  logic                    idx_done;
  logic [MAW-1:0]          rd_addr, addr_q;

  logic [MW-1:0]           mem [EntUsed];
  logic [MW-1:0]           rdata_q;
  logic                    mem_we;
  logic [MAW-1:0]          mem_waddr;
  logic [MW-1:0]           mem_wdata;

  logic                    out_valid_q;
  lvp_out_t                out_data_q, res;

  logic [63:0]             old_value, new_value;
  logic [7:0]              ctr8, dec8, ctr_upd8, rt8, iq8;
  logic [COUNTER_BITS-1:0] new_ctr;
  logic                    is_update, match, used, mispred;
  logic                    hit_evt, miss_evt, hit_wrap, miss_wrap;
  logic [7:0]              hit_inc, miss_inc;
  logic signed [BiasW-1:0] bias_up, bias_dn;
  logic signed [7:0]       conf;

  // Reduce the load PC to a table index.
  if (Pow2) begin : g_idx_mask
    assign idx      = in_q.load_pc[IW-1:0];
    assign idx_done = 1'b1;
  end else begin : g_idx_mod
    // Eight PC bits per cycle, MSB first, each a shift and conditional subtract.
    logic [63:0] pc_sh_q;
    logic [IW-1:0] rem_q;
    logic [3:0] step_q;
    logic [IW:0] acc;

    always_comb begin
      acc = {1'b0, rem_q};
      for (int k = 0; k < 8; k++) begin
        acc = {acc[IW-1:0], pc_sh_q[63-k]};
        if (acc >= (IW+1)'(TABLE_ENTRIES)) begin
          acc = acc - (IW+1)'(TABLE_ENTRIES);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= 4'd8;
      end else if (cmd_i.load) begin
        step_q <= 4'd0;
      end else if (step_q != 4'd8) begin
        step_q <= step_q + 4'd1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        pc_sh_q <= in_data_i.load_pc;
        rem_q   <= '0;
      end else if (step_q != 4'd8) begin
        pc_sh_q <= {pc_sh_q[55:0], 8'd0};
        rem_q   <= acc[IW-1:0];
      end
    end

    assign idx      = rem_q;
    assign idx_done = (step_q == 4'd8);
  end

  assign rd_addr = MAW'(idx) + (((THREADS > 1) && in_q.thread) ? MAW'(TABLE_ENTRIES) : '0);

  // Evaluation of one beat against the entry read.
  always_comb begin
    old_value = rdata_q[MW-1:COUNTER_BITS];
    ctr8      = 8'(rdata_q[COUNTER_BITS-1:0]);
    dec8      = 8'(dec_q);
    is_update = (in_q.command == CMD_UPDATE);
    match     = (in_q.predicted_value == in_q.loaded_value);
    used      = !in_q.predicted_confidence[7];
    mispred   = used && !match;

    if (match) begin
      ctr_upd8 = (ctr8 < CMAX8) ? ctr8 + 8'd1 : ctr8;
    end else begin
      ctr_upd8 = (ctr8 > dec8) ? ctr8 - dec8 : 8'd0;
    end
    rt8       = (8'(reset_to_q) > CMAX8) ? CMAX8 : 8'(reset_to_q);
    iq8       = (8'(iq_q) > CMAX8) ? CMAX8 : 8'(iq_q);
    new_ctr   = COUNTER_BITS'(mispred ? rt8 : ctr_upd8);
    new_value = match ? old_value : in_q.loaded_value;

    hit_evt   = cmd_i.ex_en && is_update && !used && match;
    miss_evt  = cmd_i.ex_en && is_update && mispred;
    hit_inc   = hit_q + 8'd1;
    miss_inc  = miss_q + 8'd1;
    hit_wrap  = (hit_inc >= hit_th_q);
    miss_wrap = (miss_inc >= miss_th_q);
    bias_up   = (bias_q == BIAS_MAX) ? bias_q : bias_q + 7'sd1;
    bias_dn   = (bias_q == BIAS_MIN) ? bias_q : bias_q - 7'sd1;

    conf = signed'(ctr8) - 8'(bias_q);

    if (is_update) begin
      res.value_guess      = '0;
      res.confidence_out   = '0;
      res.not_mispredicted = !mispred;
    end else begin
      res.value_guess      = old_value;
      res.confidence_out   = conf;
      res.not_mispredicted = 1'b1;
    end

    mem_we    = cmd_i.clr_en || (cmd_i.ex_en && is_update);
    mem_waddr = cmd_i.clr_en ? clr_addr_q : addr_q;
    mem_wdata = cmd_i.clr_en ? {64'd0, COUNTER_BITS'(iq8)} : {new_value, new_ctr};
  end

  // Table and payload registers.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
      addr_q  <= rd_addr;
    end
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.ex_en) begin
      out_data_q <= res;
    end
  end

  // Configuration, counts, bias, clearing address and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_th_q     <= 8'd16;
      miss_th_q    <= 8'd16;
      reset_to_q   <= 4'd0;
      dec_q        <= 4'd1;
      iq_q         <= 4'd0;
      hit_q        <= '0;
      miss_q       <= '0;
      bias_q       <= '0;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (lvp_cfg_e'(cfg_idx_i))
          CFG_HIT_THRESHOLD:   hit_th_q   <= cfg_wdata_i;
          CFG_MISS_THRESHOLD:  miss_th_q  <= cfg_wdata_i;
          CFG_RESET_TO:        reset_to_q <= cfg_wdata_i[3:0];
          CFG_DECREMENT_BY:    dec_q      <= cfg_wdata_i[3:0];
          CFG_INITIAL_QUALITY: iq_q       <= cfg_wdata_i[3:0];
          CFG_BIAS_START: begin
            // The start value only ever reloads the running bias.
            bias_q <= signed'(cfg_wdata_i[BiasW-1:0]);
          end
          default: ;
        endcase
      end else if (hit_evt) begin
        if (hit_wrap) begin
          hit_q  <= '0;
          bias_q <= bias_dn;
        end else begin
          hit_q <= hit_inc;
        end
      end else if (miss_evt) begin
        if (miss_wrap) begin
          miss_q <= '0;
          bias_q <= bias_up;
        end else begin
          miss_q <= miss_inc;
        end
      end

      if (status_o.reclear) begin
        clr_addr_q <= '0;
      end else if (cmd_i.clr_en) begin
        clr_addr_q <= status_o.clr_last ? '0 : clr_addr_q + MAW'(1);
      end

      if (cmd_i.ex_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o           = '0;
    status_o.idx_done  = idx_done;
    status_o.clr_last  = (clr_addr_q == MAW'(EntUsed - 1));
    status_o.reclear   = cfg_we_i && (lvp_cfg_e'(cfg_idx_i) == CFG_INITIAL_QUALITY);
    status_o.out_stall = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_en && cmd_i.ex_en))
    else $error("clearing sweep and evaluation both write the table");

  a_valid_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.ex_en))
    else $error("result presented without an evaluation");

  a_bias_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we_i && (lvp_cfg_e'(cfg_idx_i) == CFG_BIAS_START))
      |-> (bias_q == $past(signed'(cfg_wdata_i[BiasW-1:0]))))
    else $error("bias not loaded from its start value");

endmodule

// ===== src/load_value_predictor.sv =====
// Load value predictor: per-thread last-value table with saturating confidence.
// A beat is captured in the input register, its table entry is read into a register
// and it is evaluated into the output register, waiting while the output is stalled;
// a new beat is taken only once the last one is evaluated. A table size that is not
// a power of two adds a PC reduction, 8 bits per cycle. After reset and each write of
// initial_quality, a clearing sweep of 2*TABLE_ENTRIES entries (TABLE_ENTRIES for
// one thread) runs with input ready low; configuration writes are still taken.
module load_value_predictor #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned THREADS       = 2,
  parameter int unsigned COUNTER_BITS  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lvp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lvp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lvp_pkg::lvp_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lvp_pkg::lvp_out_t             out_data_o
);
  import lvp_pkg::*;

  // The controller only sequences; all storage and arithmetic sit in the datapath.
  lvp_cmd_t    cmd;
  lvp_status_t status;

  lvp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The output register parts the sides: a new beat is accepted while the
  // previous result still waits to be taken.
  lvp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .THREADS       (THREADS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
